FILE: hw/rtl/chr_pkg.sv
`timescale 1ns / 1ps
package chr_pkg;

   localparam int OP_W     = 2;
   localparam int NODE_W   = 4;
   localparam int HASH_W   = 64;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [NODE_W-1:0] node;
      logic [HASH_W-1:0] point_hash;
      logic [HASH_W-1:0] key_hash;
   } req_type;

   typedef struct packed {
      logic              active;
      logic              have_ge;
      logic [HASH_W-1:0] best_ge;
      logic [NODE_W-1:0] own_ge;
      logic              have_any;
      logic [HASH_W-1:0] best_min;
      logic [NODE_W-1:0] own_min;
      logic              dup;
      logic              free_found;
   } token_type;

   typedef struct packed {
      logic              en;
      logic [HASH_W-1:0] pos;
      logic [NODE_W-1:0] owner;
   } write_type;

endpackage

FILE: hw/rtl/chr_if.sv
`timescale 1ns / 1ps
interface chr_req_if;
   logic                        valid;
   logic                        ready;
   logic [chr_pkg::OP_W-1:0]    opcode;
   logic [chr_pkg::NODE_W-1:0]  node;
   logic [chr_pkg::HASH_W-1:0]  point_hash;
   logic [chr_pkg::HASH_W-1:0]  key_hash;
   modport source (output valid, opcode, node, point_hash, key_hash, input ready);
   modport sink (input valid, opcode, node, point_hash, key_hash, output ready);
endinterface

interface chr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [chr_pkg::NODE_W-1:0]    owner;
   logic [chr_pkg::STATUS_W-1:0]  status;
   modport source (output valid, owner, status, input ready);
   modport sink (input valid, owner, status, output ready);
endinterface

FILE: hw/rtl/chr_cell.sv
`timescale 1ns / 1ps
module chr_cell #(
   parameter int IDX_W = 8,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  chr_pkg::req_type     req,
   input  chr_pkg::token_type   tok_in,
   input  logic [IDX_W-1:0]     idx_in,
   output chr_pkg::token_type   tok_out,
   output logic [IDX_W-1:0]     idx_out,
   input  chr_pkg::write_type   wr,
   input  logic [IDX_W-1:0]     wr_idx
);
   import chr_pkg::*;

   logic              valid_ff, valid_in;
   logic [HASH_W-1:0] pos_ff, pos_in;
   logic [NODE_W-1:0] owner_ff, owner_in;
   token_type         tok_ff, tok_in_next;
   logic [IDX_W-1:0]  idx_ff, idx_in_next;

   always_comb begin
      tok_in_next = tok_in;
      idx_in_next = idx_in;
      valid_in    = valid_ff;
      pos_in      = pos_ff;
      owner_in    = owner_ff;
      if (tok_in.active) begin
         case (req.opcode)
            OP_INSERT: begin
               if (valid_ff && pos_ff == req.point_hash) begin
                  owner_in        = req.node;
                  tok_in_next.dup = 1'b1;
               end else if (!valid_ff && !tok_in.free_found) begin
                  tok_in_next.free_found = 1'b1;
                  idx_in_next            = IDX_W'(INDEX);
               end
            end
            OP_REMOVE: begin
               if (valid_ff && owner_ff == req.node) begin
                  valid_in = 1'b0;
               end
            end
            OP_LOOKUP: begin
               if (valid_ff) begin
                  if (!tok_in.have_any || pos_ff < tok_in.best_min) begin
                     tok_in_next.have_any = 1'b1;
                     tok_in_next.best_min = pos_ff;
                     tok_in_next.own_min  = owner_ff;
                  end
                  if (pos_ff >= req.key_hash &&
                      (!tok_in.have_ge || pos_ff < tok_in.best_ge)) begin
                     tok_in_next.have_ge = 1'b1;
                     tok_in_next.best_ge = pos_ff;
                     tok_in_next.own_ge  = owner_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (wr.en && wr_idx == IDX_W'(INDEX)) begin
         valid_in = 1'b1;
         pos_in   = wr.pos;
         owner_in = wr.owner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
      pos_ff   <= pos_in;
      owner_ff <= owner_in;
      idx_ff   <= idx_in_next;
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule

FILE: hw/rtl/consistent_hash_ring_top.sv
`timescale 1ns / 1ps
// A request is accepted only in the idle state, so a new request is not taken until the
// response to the last one has been loaded. The token passes once through the chain of
// point cells, one cell per cycle; its result is then held in the pending registers and
// moves to the response register once the response channel is free.
// Reset: synchronous; clears every point valid bit and all handshake state at once.
module consistent_hash_ring_top #(
   parameter int NODES           = 16,
   parameter int POINTS_PER_NODE = 16
) (
   input logic      clock,
   input logic      reset,
   chr_req_if.sink  req_chan,
   chr_rsp_if.source rsp_chan
);
   import chr_pkg::*;

   localparam int DEPTH = NODES * POINTS_PER_NODE;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_BUSY  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]          state_ff, state_in;
   req_type             req_ff;
   logic                start_ff;
   write_type           wr_ff, wr_in;
   logic [IDX_W-1:0]    wr_idx_ff;
   logic [NODE_W-1:0]   pend_owner_ff, pend_owner_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                rsp_valid_ff;
   logic [NODE_W-1:0]   rsp_owner_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                accept;
   logic                load_rsp;

   token_type        tok [DEPTH+1];
   logic [IDX_W-1:0] idx [DEPTH+1];
   token_type        tail;

   always_comb begin
      tok[0]        = '0;
      tok[0].active = start_ff;
      idx[0]        = '0;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      chr_cell #(.IDX_W(IDX_W), .INDEX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .req     (req_ff),
         .tok_in  (tok[g]),
         .idx_in  (idx[g]),
         .tok_out (tok[g+1]),
         .idx_out (idx[g+1]),
         .wr      (wr_ff),
         .wr_idx  (wr_idx_ff)
      );
   end

   assign tail     = tok[DEPTH];
   assign accept   = req_chan.valid && req_chan.ready;
   assign load_rsp = (state_ff == S_DRAIN) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      wr_in          = '0;
      wr_in.pos      = req_ff.point_hash;
      wr_in.owner    = req_ff.node;
      pend_owner_in  = '0;
      pend_status_in = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (tail.active) begin
               state_in = S_DRAIN;
               case (req_ff.opcode)
                  OP_INSERT: begin
                     if (!tail.dup) begin
                        if (tail.free_found) begin
                           wr_in.en = 1'b1;
                        end else begin
                           pend_status_in = ST_FULL;
                        end
                     end
                  end
                  OP_LOOKUP: begin
                     if (!tail.have_any) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        pend_owner_in = tail.have_ge ? tail.own_ge : tail.own_min;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAIN: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         wr_ff.en     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         wr_ff.en <= wr_in.en;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      wr_ff.pos   <= wr_in.pos;
      wr_ff.owner <= wr_in.owner;
      wr_idx_ff   <= idx[DEPTH];
      if (accept) begin
         req_ff.opcode     <= req_chan.opcode;
         req_ff.node       <= req_chan.node;
         req_ff.point_hash <= req_chan.point_hash;
         req_ff.key_hash   <= req_chan.key_hash;
      end
      if (state_ff == S_BUSY && tail.active) begin
         pend_owner_ff  <= pend_owner_in;
         pend_status_ff <= pend_status_in;
      end
      if (load_rsp) begin
         rsp_owner_ff  <= pend_owner_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.owner  = rsp_owner_ff;
   assign rsp_chan.status = rsp_status_ff;

   a_tail_busy : assert property (@(posedge clock) disable iff (reset)
      tail.active |-> state_ff == S_BUSY)
      else $error("Token left the chain outside a busy phase.");

   a_write_insert : assert property (@(posedge clock) disable iff (reset)
      wr_ff.en |-> req_ff.opcode == OP_INSERT && state_ff == S_DRAIN)
      else $error("Point write issued for something other than a fresh insert.");

   a_full_owner : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_owner_ff == '0)
      else $error("Failed beat carries a non-zero owner.");

   a_start_once : assert property (@(posedge clock) disable iff (reset)
      start_ff |-> $past(accept) && state_ff == S_BUSY)
      else $error("Token launched without an accepted request.");

endmodule
